[rtl/core/piecewise_linear_colormap_defines.svh]
// Assertion macros shared by the colormap RTL.
// Included by modules that carry concurrent checks; expects clk_i and rst_ni in scope.
`ifndef PIECEWISE_LINEAR_COLORMAP_DEFINES_SVH
`define PIECEWISE_LINEAR_COLORMAP_DEFINES_SVH

`ifndef SYNTHESIS

// Implication-style check, sampled on clk_i, off while reset is held
`define PLM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never be seen at a clock edge
`define PLM_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define PLM_ASSERT(label, prop, msg)
`define PLM_NEVER(label, cond, msg)

`endif

`endif

[rtl/core/plm_pkg.sv]
// Shared types, constants and reset tables for the piecewise-linear colormap.
// No dependencies; used by every module of the block.
package plm_pkg;

  // Fixed-point format of intensities and breakpoint positions
  localparam int FRAC_BITS = 16;
  localparam int POS_W     = FRAC_BITS + 1;
  localparam int CHAN_W    = 8;
  localparam int NUM_CHAN  = 4;
  localparam int RGBA_W    = NUM_CHAN * CHAN_W;
  localparam int BP_W      = POS_W + RGBA_W;

  localparam logic [POS_W-1:0]  ONE_Q    = POS_W'(1) << FRAC_BITS;
  localparam logic [CHAN_W-1:0] CHAN_MAX = '1;

  // Defaults for top-level parameters
  localparam int NUM_BREAKPOINTS_DEF = 7;
  localparam int QUEUE_DEPTH_DEF     = 2;

  // Entries in the built-in jet table
  localparam int JET_LEN = 7;

  // One classified item handed from the front end to the back end
  typedef struct packed {
    logic              gray;
    logic [POS_W-1:0]  value;
    logic [POS_W-1:0]  lo;
    logic [POS_W-1:0]  hi;
    logic [RGBA_W-1:0] c0;
    logic [RGBA_W-1:0] c1;
  } plm_job_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_BLEND,
    ST_DONE
  } plm_state_e;

  // Jet table entry: position is round(frac * 1.0) in Q16, then RGBA
  function automatic logic [BP_W-1:0] jet_entry(input int idx);
    logic [BP_W-1:0] e;
    case (idx)
      0:       e = {POS_W'(0),     32'h00008FFF};  // 0
      1:       e = {POS_W'(7282),  32'h0000FFFF};  // 1/9
      2:       e = {POS_W'(23926), 32'h00FFFFFF};  // 23/63
      3:       e = {POS_W'(40570), 32'hFFFF00FF};  // 13/21
      4:       e = {POS_W'(48892), 32'hFF7F00FF};  // 47/63
      5:       e = {POS_W'(57214), 32'hFF0000FF};  // 55/63
      default: e = {ONE_Q,         32'h7F0000FF};  // 1.0
    endcase
    return e;
  endfunction

  // Reset value of breakpoint idx out of num; the tail and last entry take the end of jet
  function automatic logic [BP_W-1:0] bp_reset(input int idx, input int num);
    int sel;
    sel = ((idx < num - 1) && (idx < JET_LEN - 1)) ? idx : JET_LEN - 1;
    return jet_entry(sel);
  endfunction

endpackage

[rtl/core/plm_front.sv]
// Front end: configuration registers, input transfer, clamp and segment search.
// Depends on plm_pkg; feeds classified items to plm_queue.
module plm_front import plm_pkg::*; #(
  parameter int NUM_BREAKPOINTS = NUM_BREAKPOINTS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [$clog2(NUM_BREAKPOINTS+1)-1:0]   cfg_idx_i,
  input  logic [BP_W-1:0]                        cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [POS_W-1:0]                       value_in_i,
  output logic                                   push_o,
  output plm_job_t                               job_o,
  input  logic                                   full_i
);

  localparam int CFG_IDX_W = $clog2(NUM_BREAKPOINTS + 1);
  localparam int BP_IDX_W  = $clog2(NUM_BREAKPOINTS);
  localparam logic [CFG_IDX_W-1:0] IDX_GRAY = CFG_IDX_W'(NUM_BREAKPOINTS);
  localparam int GRAY_W = POS_W + CHAN_W;

  logic [BP_W-1:0]            bp_q [NUM_BREAKPOINTS];
  logic                       gray_q;
  logic [POS_W-1:0]           val_clamp;
  logic [NUM_BREAKPOINTS-1:0] above;
  logic [NUM_BREAKPOINTS-2:0] seg_oh;
  logic [POS_W-1:0]           seg_lo, seg_hi;
  logic [RGBA_W-1:0]          seg_c0, seg_c1;
  logic [GRAY_W-1:0]          gray_full;
  logic [CHAN_W-1:0]          gray_lvl;

  // Register writes; out-of-range indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_BREAKPOINTS; i++) begin
        bp_q[i] <= bp_reset(i, NUM_BREAKPOINTS);
      end
      gray_q <= 1'b0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i < IDX_GRAY) begin
        bp_q[cfg_idx_i[BP_IDX_W-1:0]] <= cfg_data_i;
      end else if (cfg_idx_i == IDX_GRAY) begin
        gray_q <= cfg_data_i[0];
      end
    end
  end

  // Input clamp to 1.0
  assign val_clamp = (value_in_i > ONE_Q) ? ONE_Q : value_in_i;

  // Compare against every breakpoint position in parallel
  always_comb begin
    for (int j = 0; j < NUM_BREAKPOINTS; j++) begin
      above[j] = val_clamp > bp_q[j][BP_W-1 -: POS_W];
    end
  end

  // Segment k: past every upper bound below it, and at or under its own (last segment catches all)
  always_comb begin
    logic reach;
    for (int j = 0; j < NUM_BREAKPOINTS - 1; j++) begin
      reach = 1'b1;
      for (int m = 1; m <= j; m++) begin
        reach = reach & above[m];
      end
      seg_oh[j] = reach && ((j == NUM_BREAKPOINTS - 2) || !above[j+1]);
    end
  end

  // One-hot select of both segment ends
  always_comb begin
    seg_lo = '0;
    seg_hi = '0;
    seg_c0 = '0;
    seg_c1 = '0;
    for (int j = 0; j < NUM_BREAKPOINTS - 1; j++) begin
      seg_lo = seg_lo | ({POS_W{seg_oh[j]}}  & bp_q[j][BP_W-1 -: POS_W]);
      seg_hi = seg_hi | ({POS_W{seg_oh[j]}}  & bp_q[j+1][BP_W-1 -: POS_W]);
      seg_c0 = seg_c0 | ({RGBA_W{seg_oh[j]}} & bp_q[j][RGBA_W-1:0]);
      seg_c1 = seg_c1 | ({RGBA_W{seg_oh[j]}} & bp_q[j+1][RGBA_W-1:0]);
    end
  end

  // Gray ramp: v*255 as v*256 - v
  assign gray_full = {val_clamp, {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, val_clamp};
  assign gray_lvl  = gray_full[FRAC_BITS +: CHAN_W];

  // Classified item; gray items carry their finished pixel in c0
  always_comb begin
    job_o.gray  = gray_q;
    job_o.value = val_clamp;
    job_o.lo    = seg_lo;
    job_o.hi    = seg_hi;
    job_o.c0    = gray_q ? {gray_lvl, gray_lvl, gray_lvl, CHAN_MAX} : seg_c0;
    job_o.c1    = seg_c1;
  end

  // Input transfer whenever the queue has room
  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

endmodule

[rtl/core/plm_queue.sv]
// Short FIFO of classified items between the front and back ends.
// Depends on plm_pkg and the colormap assertion macros.
`include "piecewise_linear_colormap_defines.svh"

module plm_queue import plm_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  plm_job_t job_i,
  output logic     full_o,
  input  logic     pop_i,
  output plm_job_t job_o,
  output logic     empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  plm_job_t         slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= job_i;
    end
  end

  assign job_o   = slot_q[rd_ptr_q];
  assign full_o  = cnt_q == CNT_W'(DEPTH);
  assign empty_o = cnt_q == '0;

  `PLM_NEVER(a_queue_overflow, push_i && full_o, "queue push while full")
  `PLM_NEVER(a_queue_cnt_range, cnt_q > CNT_W'(DEPTH), "queue count past depth")
  `PLM_ASSERT(a_queue_cnt_step, (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + CNT_W'(1)), "queue count missed a push")

endmodule

[rtl/core/plm_back.sv]
// Back end: segment fraction by restoring division, per-channel blend, output register.
// Depends on plm_pkg and the colormap assertion macros; takes items from plm_queue.
`include "piecewise_linear_colormap_defines.svh"

module plm_back import plm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  plm_job_t          job_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [CHAN_W-1:0] red_o,
  output logic [CHAN_W-1:0] green_o,
  output logic [CHAN_W-1:0] blue_o,
  output logic [CHAN_W-1:0] alpha_o
);

  localparam int STEP_W = $clog2(FRAC_BITS);
  localparam int ACC_W  = CHAN_W + 1 + POS_W + 1;
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(ONE_Q >> 1);

  plm_state_e         state_q, state_d;
  logic [STEP_W-1:0]  step_q, step_d;
  logic               out_valid_q, out_valid_d;
  plm_job_t           job_q, job_d;
  logic [RGBA_W-1:0]  c0_q, c0_d, c1_q, c1_d;
  logic [POS_W-1:0]   rem_q, rem_d, den_q, den_d, fu_q, fu_d;
  logic signed [ACC_W-1:0] prod_q, prod_d;
  logic [CHAN_W-1:0]  base_q, base_d;
  logic [RGBA_W-1:0]  res_q, res_d, pix_q, pix_d;

  logic [POS_W-1:0]   seg_num, seg_den;
  logic [POS_W:0]     rem_sh, div_sub;
  logic               div_ge;
  logic signed [CHAN_W:0]  chan_diff;
  logic signed [POS_W:0]   fu_s;
  logic signed [ACC_W-1:0] base_s, acc;

  // Segment offsets for classification
  assign seg_num = job_q.value - job_q.lo;
  assign seg_den = job_q.hi - job_q.lo;

  // One restoring-division step
  assign rem_sh  = {rem_q, 1'b0};
  assign div_ge  = rem_sh >= {1'b0, den_q};
  assign div_sub = rem_sh - {1'b0, den_q};

  // Blend as c0*1.0 + (c1-c0)*fu + 0.5, one channel per cycle, red first
  assign chan_diff = $signed({1'b0, c1_q[RGBA_W-1 -: CHAN_W]})
                   - $signed({1'b0, c0_q[RGBA_W-1 -: CHAN_W]});
  assign fu_s   = $signed({1'b0, fu_q});
  assign base_s = $signed({{(ACC_W-CHAN_W-FRAC_BITS){1'b0}}, base_q, {FRAC_BITS{1'b0}}});
  assign acc    = base_s + prod_q + HALF;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    pop_o       = 1'b0;
    job_d       = job_q;
    c0_d        = c0_q;
    c1_d        = c1_q;
    rem_d       = rem_q;
    den_d       = den_q;
    fu_d        = fu_q;
    prod_d      = prod_q;
    base_d      = base_q;
    res_d       = res_q;
    pix_d       = pix_q;

    // Output transfer frees the slot
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          job_d   = job_i;
          c0_d    = job_i.c0;
          c1_d    = job_i.c1;
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        step_d = '0;
        if (job_q.gray) begin
          res_d   = c0_q;
          state_d = ST_DONE;
        end else if (!((job_q.hi > job_q.lo) && (job_q.value > job_q.lo))) begin
          // empty segment or value at its start
          fu_d    = '0;
          state_d = ST_BLEND;
        end else if (seg_num >= seg_den) begin
          // at or past the upper end: fraction saturates
          fu_d    = ONE_Q;
          state_d = ST_BLEND;
        end else begin
          rem_d   = seg_num;
          den_d   = seg_den;
          fu_d    = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_d  = div_ge ? div_sub[POS_W-1:0] : rem_sh[POS_W-1:0];
        fu_d   = {fu_q[POS_W-2:0], div_ge};
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(FRAC_BITS - 1)) begin
          step_d  = '0;
          state_d = ST_BLEND;
        end
      end
      ST_BLEND: begin
        if (step_q < STEP_W'(NUM_CHAN)) begin
          prod_d = chan_diff * fu_s;
          base_d = c0_q[RGBA_W-1 -: CHAN_W];
          c0_d   = c0_q << CHAN_W;
          c1_d   = c1_q << CHAN_W;
        end
        if (step_q != '0) begin
          res_d = {res_q[RGBA_W-CHAN_W-1:0], acc[FRAC_BITS +: CHAN_W]};
        end
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(NUM_CHAN)) begin
          step_d  = '0;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          pix_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    job_q  <= job_d;
    c0_q   <= c0_d;
    c1_q   <= c1_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
    fu_q   <= fu_d;
    prod_q <= prod_d;
    base_q <= base_d;
    res_q  <= res_d;
    pix_q  <= pix_d;
  end

  assign out_valid_o = out_valid_q;
  assign red_o       = pix_q[RGBA_W-1 -: CHAN_W];
  assign green_o     = pix_q[RGBA_W-CHAN_W-1 -: CHAN_W];
  assign blue_o      = pix_q[CHAN_W +: CHAN_W];
  assign alpha_o     = pix_q[CHAN_W-1:0];

  `PLM_ASSERT(a_pop_nonempty, pop_o |-> !empty_i, "back end popped an empty queue")
  `PLM_ASSERT(a_div_rem_range, (state_q == ST_DIV) |-> (rem_q < den_q), "division remainder not below divisor")
  `PLM_ASSERT(a_fu_range, (state_q == ST_BLEND) |-> (fu_q <= ONE_Q), "segment fraction above one")

endmodule

[rtl/core/piecewise_linear_colormap.sv]
// An item passes the queue, then the back-end states IDLE, LOAD, DIV (the 16-step
// divider, only when the segment fraction is neither 0 nor 1), BLEND (skipped in
// gray mode) and DONE. The back end takes one item at a time, and the queue keeps
// taking items while a result waits, until the queue is full.
// Reset (async, active low): queue empty, jet table loaded, gray mode off.
module piecewise_linear_colormap import plm_pkg::*; #(
  parameter int NUM_BREAKPOINTS = NUM_BREAKPOINTS_DEF,
  parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [$clog2(NUM_BREAKPOINTS+1)-1:0] cfg_idx_i,
  input  logic [BP_W-1:0]                      cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [POS_W-1:0]                     value_in_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [CHAN_W-1:0]                    red_o,
  output logic [CHAN_W-1:0]                    green_o,
  output logic [CHAN_W-1:0]                    blue_o,
  output logic [CHAN_W-1:0]                    alpha_o
);

  logic     push, full, pop, empty;
  plm_job_t job_in, job_out;

  // Accept, clamp, find segment
  plm_front #(
    .NUM_BREAKPOINTS(NUM_BREAKPOINTS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .value_in_i (value_in_i),
    .push_o     (push),
    .job_o      (job_in),
    .full_i     (full)
  );

  // Decoupling queue
  plm_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .job_o   (job_out),
    .empty_o (empty)
  );

  // Divide, blend, drive result
  plm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .job_i       (job_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o),
    .alpha_o     (alpha_o)
  );

endmodule

[bench/piecewise_linear_colormap_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for piecewise_linear_colormap: jet, gray, random and degenerate
// breakpoint tables, random handshake gaps and a long output hold-off.
// Depends on plm_pkg and the piecewise_linear_colormap RTL only.
module piecewise_linear_colormap_tb;
  import plm_pkg::*;

  localparam int NUM_BP        = NUM_BREAKPOINTS_DEF;
  localparam int IDX_W         = $clog2(NUM_BP + 1);
  localparam int GRAY_MODE_IDX = NUM_BP;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int MAX_REPORTS   = 10;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
  } pixel_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [IDX_W-1:0]  cfg_idx_i;
  logic [BP_W-1:0]   cfg_data_i;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [POS_W-1:0]  value_in_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [CHAN_W-1:0] red_o;
  logic [CHAN_W-1:0] green_o;
  logic [CHAN_W-1:0] blue_o;
  logic [CHAN_W-1:0] alpha_o;

  piecewise_linear_colormap DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_in_i  (value_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o),
    .alpha_o     (alpha_o)
  );

  // Bench copy of the register file, plus the staging table for the next load
  logic [BP_W-1:0] bp_tab   [NUM_BP];
  logic [BP_W-1:0] next_tab [NUM_BP];
  logic            gray_on;

  // Jet defaults: position = round(num/den * 1.0), then RGBA
  int unsigned     jet_num  [JET_LEN] = '{0, 1, 23, 13, 47, 55, 1};
  int unsigned     jet_den  [JET_LEN] = '{1, 9, 63, 21, 63, 63, 1};
  logic [31:0]     jet_rgba [JET_LEN] = '{32'h00008FFF, 32'h0000FFFF, 32'h00FFFFFF,
                                          32'hFFFF00FF, 32'hFF7F00FF, 32'hFF0000FF,
                                          32'h7F0000FF};

  pixel_t pixel_q[$];
  pixel_t exp_px;
  int     fail_count = 0;
  int     cycle_count = 0;
  bit     idling = 1'b1;
  int     hold_len = 0;
  int     stall_run = 0;
  bit     stall_now;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [POS_W-1:0] seg_pos(input int i);
    return bp_tab[i][BP_W-1 -: POS_W];
  endfunction

  // Expected pixel for one intensity under the current table and mode
  function automatic pixel_t map_pixel(input logic [POS_W-1:0] raw);
    logic [63:0]       v, lo, hi, frac, acc;
    logic [CHAN_W-1:0] chan [NUM_CHAN];
    int                k;
    v = 64'(raw);
    if (v > 64'(ONE_Q)) v = 64'(ONE_Q);
    if (gray_on) begin
      acc = (v * 64'd255) >> FRAC_BITS;
      return '{acc[7:0], acc[7:0], acc[7:0], CHAN_MAX};
    end
    // first segment whose upper end covers v; the last one catches the rest
    k = 0;
    while (k < NUM_BP - 2 && v > 64'(seg_pos(k + 1))) k++;
    lo   = 64'(seg_pos(k));
    hi   = 64'(seg_pos(k + 1));
    frac = 64'd0;
    if (hi > lo && v > lo) begin
      frac = ((v - lo) << FRAC_BITS) / (hi - lo);
      if (frac > 64'(ONE_Q)) frac = 64'(ONE_Q);
    end
    for (int c = 0; c < NUM_CHAN; c++) begin
      acc = 64'(bp_tab[k][24 - 8 * c +: 8]) * (64'(ONE_Q) - frac)
          + 64'(bp_tab[k + 1][24 - 8 * c +: 8]) * frac + (64'(ONE_Q) >> 1);
      chan[c] = acc[FRAC_BITS +: CHAN_W];
    end
    return '{chan[0], chan[1], chan[2], chan[3]};
  endfunction

  // Gap or stall length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    if (!idling) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [BP_W-1:0] rand_reg();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[BP_W-1:0];
  endfunction

  // Random intensity: plain range, exactly one, above one, or hugging a breakpoint
  function automatic logic [POS_W-1:0] rand_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8)  return ONE_Q;
    if (r < 16) return ONE_Q | POS_W'($urandom_range(0, 65535));
    if (r < 30) return seg_pos($urandom_range(0, NUM_BP - 1))
                       + POS_W'($urandom_range(0, 4)) - POS_W'(2);
    return POS_W'($urandom_range(0, 65535));
  endfunction

  // Output side: check each transfer, then pick the next stall level
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      if (pixel_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected pixel r=%0d g=%0d b=%0d a=%0d", red_o, green_o, blue_o,
                   alpha_o);
      end else begin
        exp_px = pixel_q.pop_front();
        if (red_o !== exp_px.red || green_o !== exp_px.green ||
            blue_o !== exp_px.blue || alpha_o !== exp_px.alpha) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("pixel mismatch: exp r=%0d g=%0d b=%0d a=%0d got r=%0d g=%0d b=%0d a=%0d",
                     exp_px.red, exp_px.green, exp_px.blue, exp_px.alpha,
                     red_o, green_o, blue_o, alpha_o);
        end
      end
    end
    if (hold_len > 0) begin
      out_stall_i <= 1'b1;
      hold_len--;
      stall_run = 0;
    end else if (stall_run > 0) begin
      stall_run--;
    end else begin
      stall_now = idling && ($urandom_range(0, 2) == 0);
      stall_run = stall_now ? idle_len() : $urandom_range(1, 8);
      out_stall_i <= stall_now;
    end
  end

  // One intensity transfer; valid stays up when no gap follows
  task automatic send_value(input logic [POS_W-1:0] v);
    int gap;
    in_valid_i <= 1'b1;
    value_in_i <= v;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pixel_q = {pixel_q, map_pixel(v)};
    gap = idle_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_random(input int count);
    repeat (count) send_value(rand_value());
  endtask

  // Every item yields one pixel, so an empty queue means the block is idle
  task automatic drain();
    in_valid_i <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk_i);
  endtask

  // Write all breakpoints from next_tab, then the mode register
  task automatic load_config(input logic [BP_W-1:0] gray_word);
    drain();
    for (int i = 0; i < NUM_BP; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= IDX_W'(i);
      cfg_data_i <= next_tab[i];
      @(posedge clk_i);
      bp_tab[i] = next_tab[i];
    end
    cfg_idx_i  <= IDX_W'(GRAY_MODE_IDX);
    cfg_data_i <= gray_word;
    @(posedge clk_i);
    gray_on = gray_word[0];
    cfg_we_i <= 1'b0;
  endtask

  // Strictly rising positions from 0 to one; tight packs the interior near zero
  task automatic make_rising_table(input bit tight);
    int pos, room, mx;
    pos = 0;
    for (int i = 0; i < NUM_BP; i++) begin
      if (i == NUM_BP - 1) begin
        pos = ONE_Q;
      end else if (i > 0) begin
        room = 65536 - (NUM_BP - 1 - i) - pos;
        mx   = tight ? 3 : 2 * room / (NUM_BP - i);
        if (mx < 1) mx = 1;
        if (mx > room) mx = room;
        pos = pos + $urandom_range(1, mx);
      end
      next_tab[i] = {POS_W'(pos), $urandom};
    end
  endtask

  task automatic make_pos_table(input int p0, p1, p2, p3, p4, p5, p6);
    int pos [NUM_BP];
    pos = '{p0, p1, p2, p3, p4, p5, p6};
    for (int i = 0; i < NUM_BP; i++) next_tab[i] = {POS_W'(pos[i]), $urandom};
  endtask

  // Reset table: every breakpoint, one past it, and the corners of the field
  task automatic test_jet_table();
    for (int k = 0; k < NUM_BP; k++) begin
      send_value(seg_pos(k));
      send_value(seg_pos(k) + POS_W'(1));
    end
    send_value(seg_pos(1) - POS_W'(1));
    send_value(17'd32768);
    send_value(17'd65535);
    send_value(17'h1FFFF);
    send_value(17'h0AAAA);
    send_value(17'h15555);
    send_value(17'h10000 | 17'($urandom_range(1, 65535)));
    send_random(80);
  endtask

  // Gray ramp, mode word with every bit set, then with random upper bits
  task automatic test_gray_ramp();
    next_tab = bp_tab;
    load_config({BP_W{1'b1}});
    send_value(17'd0);
    send_value(17'd1);
    send_value(17'd256);
    send_value(17'd257);
    send_value(17'd32768);
    send_value(17'd65535);
    send_value(ONE_Q);
    send_value(17'h1FFFF);
    send_random(40);
    load_config(rand_reg() | BP_W'(1));
    send_random(30);
  endtask

  // Well-formed tables with random colors, one phase without any idling
  task automatic test_random_tables();
    for (int t = 0; t < 5; t++) begin
      make_rising_table(t == 3);
      load_config(rand_reg() & ~BP_W'(1));
      idling = (t != 1);
      send_random(65);
    end
    idling = 1'b1;
  endtask

  // Zero-width and unordered segments, table off the ends, all-ones and all-zero words
  task automatic test_degenerate_tables();
    make_pos_table(0, 20000, 20000, 40000, 40000, 40000, ONE_Q);
    load_config({BP_W{1'b0}});
    send_random(30);
    for (int i = 0; i < NUM_BP; i++) next_tab[i] = rand_reg();
    load_config(rand_reg() & ~BP_W'(1));
    send_random(30);
    make_pos_table(30000, 35000, 40000, 45000, 50000, 55000, 60000);
    load_config({BP_W{1'b0}});
    send_value(17'd0);
    send_value(17'd29999);
    send_value(17'd60001);
    send_random(27);
    for (int i = 0; i < NUM_BP; i++) next_tab[i] = {BP_W{1'b1}};
    load_config({{(BP_W-1){1'b1}}, 1'b0});
    send_random(20);
    for (int i = 0; i < NUM_BP; i++) next_tab[i] = {BP_W{1'b0}};
    load_config({BP_W{1'b0}});
    send_random(20);
  endtask

  // Output held off long enough for the queue to fill and stall the input
  task automatic test_backpressure();
    make_rising_table(1'b0);
    load_config({BP_W{1'b0}});
    idling   = 1'b0;
    hold_len = 300;
    send_random(60);
    idling = 1'b1;
    send_random(20);
  endtask

  initial begin
    int j, pos;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= '0;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    value_in_i  <= '0;
    out_stall_i <= 1'b0;
    // bench copy starts from the jet table, last entry at one
    for (int i = 0; i < NUM_BP; i++) begin
      j   = (i < NUM_BP - 1 && i < JET_LEN - 1) ? i : JET_LEN - 1;
      pos = (jet_num[j] * 65536 + jet_den[j] / 2) / jet_den[j];
      bp_tab[i] = {POS_W'(pos), jet_rgba[j]};
    end
    gray_on = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_jet_table();
    test_gray_ramp();
    test_random_tables();
    test_degenerate_tables();
    test_backpressure();

    drain();
    repeat (40) @(posedge clk_i);
    fail_count += pixel_q.size();
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
